### sv/pagerank_vertex_apply_assert.svh
// Assertion macros for the checker of the vertex apply block.
`ifndef PAGERANK_VERTEX_APPLY_ASSERT_SVH
`define PAGERANK_VERTEX_APPLY_ASSERT_SVH

// Clocked assertion that is switched off while the reset is held.
`define PRVA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across the reset.
`define PRVA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/prva_pkg.sv
// Package with the constants and shared types of the vertex apply block.
`timescale 1ns / 1ps

package prva_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DAMP_SHIFT      = 7;
    localparam int FIELD_W         = 32;
    localparam int DEGREE_W        = 31;
    localparam int DAMP_W          = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_SCORE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_FACTOR = 2'd1;

    localparam logic [FIELD_W-1:0] BASE_SCORE_RESET     = 32'd0;
    localparam logic [DAMP_W-1:0]  DAMPING_FACTOR_RESET = 16'd108;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input transaction
        logic mul;       // damping product
        logic add;       // damped score
        logic prep;      // error update and divider setup
        logic div_step;  // one quotient bit
        logic fin;       // load the output register
    } prva_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;  // the current step yields the last quotient bit
        logic out_free;  // the output register can take a result
    } prva_status_t;

endpackage

### sv/pagerank_vertex_apply.sv
// Top level of the vertex apply block: one vertex score update per transaction.
// Each vertex passes through multiply, add, error update, VALUE_WIDTH division steps and
// the output load. A new vertex is accepted only once the last one is loaded into the
// output register. The radix-2 divider yields one quotient bit per cycle.
// Reset (aresetn, synchronous, active low) clears the error total, the output
// valid and the controller, and restores base_score 0 and damping_factor 108.
`timescale 1ns / 1ps

module pagerank_vertex_apply
    import prva_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port: index 0 is base_score, index 1 damping_factor.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream, one vertex per transaction.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata from bit 0: rank_sum[31:0], prior_score[63:32], out_degree[94:64], zero pad[95]
    input  logic [95:0]            s_axis_tdata,
    input  logic                   s_axis_tlast,
    // Result stream, one result per vertex.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata from bit 0: new_value[31:0], run_total[63:32]
    output logic [63:0]            m_axis_tdata,
    // tlast carries error_valid: the transaction closes a run and holds its total.
    output logic                   m_axis_tlast
);

    prva_cmd_t    cmd;
    prva_status_t status;

    logic [FIELD_W-1:0] new_value, run_total;

    // The controller walks each vertex through multiply, add, error update,
    // VALUE_WIDTH division steps and the output load. It accepts a new vertex
    // only when idle, but the output register decouples the two sides: once
    // a result is parked there, the next vertex can enter while the
    // downstream side still stalls.
    prva_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the running error total,
    // the sign-magnitude restoring divider and the output register. A zero
    // out-degree lets the divider run and forces the quotient to zero at the end.
    prva_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .rank_sum    (s_axis_tdata[31:0]),
        .prior_score (s_axis_tdata[63:32]),
        .out_degree  (s_axis_tdata[94:64]),
        .last        (s_axis_tlast),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .new_value   (new_value),
        .run_total   (run_total),
        .error_valid (m_axis_tlast)
    );

    assign m_axis_tdata = {run_total, new_value};

endmodule

### sv/prva_ctrl.sv
// Controller state machine that sequences one vertex through the datapath.
`timescale 1ns / 1ps

module prva_ctrl
    import prva_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  prva_status_t status,
    output prva_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_PREP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/prva_datapath.sv
// Datapath: configuration registers, score arithmetic, radix-2 divider and output register.
`timescale 1ns / 1ps

module prva_datapath
    import prva_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [FIELD_W-1:0]     rank_sum,
    input  logic [FIELD_W-1:0]     prior_score,
    input  logic [DEGREE_W-1:0]    out_degree,
    input  logic                   last,
    input  prva_cmd_t              cmd,
    output prva_status_t           status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FIELD_W-1:0]     new_value,
    output logic [FIELD_W-1:0]     run_total,
    output logic                   error_valid
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(W - 1);

    logic [FIELD_W-1:0]  base_reg;
    logic [DAMP_W-1:0]   damp_reg;

    logic [W-1:0]        rank_reg, old_reg;
    logic [DEGREE_W-1:0] deg_reg;
    logic                last_reg;
    logic [W-1:0]        prod_reg, score_reg, acc_reg, quot_reg;
    logic                neg_reg;
    logic [DEGREE_W-1:0] rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                valid_reg;
    logic [FIELD_W-1:0]  value_reg, total_reg;
    logic                ev_reg;

    logic [W+FIELD_W-1:0] rank_ext, old_ext, base_ext;
    logic [W+DAMP_W-1:0]  prod_full;
    logic [W-1:0]         prod_shift, diff, abs_diff, score_mag, quot_signed;
    logic [DEGREE_W:0]    trial, trial_sub;
    logic                 qbit;
    logic [W+FIELD_W-1:0] quot_ext, acc_ext;

    // Extend to the working width (or cut down): rank and prior by sign, base by zeros.
    assign rank_ext = {{W{rank_sum[FIELD_W-1]}}, rank_sum};
    assign old_ext  = {{W{prior_score[FIELD_W-1]}}, prior_score};
    assign base_ext = {{W{1'b0}}, base_reg};

    assign prod_full  = W'(rank_reg) * (W+DAMP_W)'(damp_reg);
    assign prod_shift = W'($signed(prod_reg) >>> DAMP_SHIFT);

    assign diff      = score_reg - old_reg;
    assign abs_diff  = diff[W-1] ? (W'(0) - diff) : diff;
    assign score_mag = score_reg[W-1] ? (W'(0) - score_reg) : score_reg;

    // Restoring division step: the dividend shifts out at the top of
    // quot_reg while quotient bits shift in at the bottom.
    assign trial     = {rem_reg, quot_reg[W-1]};
    assign qbit      = (trial >= {1'b0, deg_reg});
    assign trial_sub = trial - {1'b0, deg_reg};

    assign quot_signed = (deg_reg == '0) ? '0 :
                         (neg_reg ? (W'(0) - quot_reg) : quot_reg);
    assign quot_ext    = {{FIELD_W{1'b0}}, quot_signed};
    assign acc_ext     = {{FIELD_W{1'b0}}, acc_reg};

    assign status.div_last = (cnt_reg == '0);
    assign status.out_free = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_SCORE_RESET;
            damp_reg <= DAMPING_FACTOR_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_BASE_SCORE) begin
                base_reg <= cfg_wdata;
            end else if (cfg_index == REG_DAMPING_FACTOR) begin
                damp_reg <= cfg_wdata[DAMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.prep) begin
                acc_reg <= acc_reg + abs_diff;
            end else if (cmd.fin && last_reg) begin
                acc_reg <= '0;
            end
            if (cmd.fin) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rank_reg <= rank_ext[W-1:0];
            old_reg  <= old_ext[W-1:0];
            deg_reg  <= out_degree;
            last_reg <= last;
        end
        if (cmd.mul) begin
            prod_reg <= prod_full[W-1:0];
        end
        if (cmd.add) begin
            score_reg <= base_ext[W-1:0] + prod_shift;
        end
        if (cmd.prep) begin
            neg_reg  <= score_reg[W-1];
            quot_reg <= score_mag;
            rem_reg  <= '0;
            cnt_reg  <= CNT_START;
        end
        if (cmd.div_step) begin
            quot_reg <= {quot_reg[W-2:0], qbit};
            rem_reg  <= qbit ? trial_sub[DEGREE_W-1:0] : trial[DEGREE_W-1:0];
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        if (cmd.fin) begin
            value_reg <= quot_ext[FIELD_W-1:0];
            total_reg <= last_reg ? acc_ext[FIELD_W-1:0] : '0;
            ev_reg    <= last_reg;
        end
    end

    assign out_valid   = valid_reg;
    assign new_value   = value_reg;
    assign run_total   = total_reg;
    assign error_valid = ev_reg;

endmodule

### sv/prva_checker.sv
// Port-level checker for the vertex apply block, bound to the top level.
`timescale 1ns / 1ps
`include "pagerank_vertex_apply_assert.svh"

module prva_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    property p_out_hold;
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast);
    endproperty

    property p_reset_quiet;
        !aresetn |=> !m_axis_tvalid;
    endproperty

    property p_total_zero;
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[63:32] == 32'd0;
    endproperty

    property p_one_item;
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready;
    endproperty

    // A stalled result keeps its payload.
    `PRVA_ASSERT(a_out_hold, aclk, aresetn, p_out_hold, "stalled result changed")

    // After a reset edge no result is offered.
    `PRVA_ASSERT_RST(a_reset_quiet, aclk, p_reset_quiet, "result valid right after reset")

    // The total is zero unless the transaction closes a run.
    `PRVA_ASSERT(a_total_zero, aclk, aresetn, p_total_zero, "run total set outside run end")

    // One vertex at a time: an accepted vertex closes the input for the next cycle.
    `PRVA_ASSERT(a_one_item, aclk, aresetn, p_one_item, "input ready right after acceptance")

endmodule

bind pagerank_vertex_apply prva_checker u_prva_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### test/pagerank_vertex_apply_tb.sv
// Self-checking testbench for the PageRank vertex apply block.
`timescale 1ns / 1ps

module pagerank_vertex_apply_tb
    import prva_pkg::*;
();

    // Cycle budget for the whole run. The slowest correct run is roughly
    // 950 vertices plus stalls on both sides, drains and the long receiver
    // hold-off.
    localparam int RUN_LIMIT    = 600_000;
    // Settle time that the drain waits after the last expected result.
    localparam int DRAIN_CYCLES = 48;
    // Length of the receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 155;
    localparam int REPORT_MAX   = 10;

    // Register indexes that decode to nothing; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [31:0] new_value;
        logic [31:0] run_total;
        logic        error_valid;
    } vertex_result_t;

    // Holds a private copy of the registers and the error total, predicts
    // the result of every accepted vertex and compares results in order.
    class vertex_scoreboard;
        logic [31:0]    base_score;
        logic [15:0]    damping_factor;
        logic [31:0]    error_total;
        vertex_result_t pending[$];
        int             mismatches;

        function new();
            base_score     = BASE_SCORE_RESET;
            damping_factor = DAMPING_FACTOR_RESET;
            error_total    = '0;
            mismatches     = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BASE_SCORE:     base_score = data;
                REG_DAMPING_FACTOR: damping_factor = data[15:0];
                default: ;
            endcase
        endfunction

        function void note_vertex(input logic [31:0] rank_sum, input logic [31:0] prior_score,
                                  input logic [30:0] out_degree, input logic last);
            logic [31:0]        product;
            logic signed [31:0] damped;
            logic [31:0]        score;
            logic [31:0]        magnitude;
            logic [31:0]        quotient;
            logic [31:0]        change;
            vertex_result_t     res;
            // The multiply wraps at 32 bits and the shift fills with the sign.
            product = {16'd0, damping_factor} * rank_sum;
            damped  = $signed(product) >>> DAMP_SHIFT;
            score   = base_score + damped;
            // Divide magnitudes so that the most negative score divides cleanly.
            magnitude = score[31] ? -score : score;
            quotient  = (out_degree == '0) ? 32'd0 : magnitude / {1'b0, out_degree};
            res.new_value = score[31] ? -quotient : quotient;
            // The score change wraps; its absolute value keeps 0x80000000 as is.
            change = score - prior_score;
            if (change[31]) begin
                change = -change;
            end
            error_total = error_total + change;
            if (last) begin
                res.run_total   = error_total;
                res.error_valid = 1'b1;
                error_total     = '0;
            end else begin
                res.run_total   = '0;
                res.error_valid = 1'b0;
            end
            pending.push_back(res);
        endfunction

        function void check_result(input logic [31:0] new_value, input logic [31:0] run_total,
                                   input logic error_valid);
            vertex_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: new_value=%h run_total=%h error_valid=%b",
                             new_value, run_total, error_valid);
                end
            end else begin
                want = pending.pop_front();
                if (new_value !== want.new_value || run_total !== want.run_total
                        || error_valid !== want.error_valid) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("result mismatch: exp %h %h %b, got %h %h %b",
                                 want.new_value, want.run_total, want.error_valid,
                                 new_value, run_total, error_valid);
                    end
                end
            end
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [95:0]            s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [63:0]            m_axis_tdata;
    logic                   m_axis_tlast;

    vertex_scoreboard sb = new();

    // Idle rates in percent for the sender and the receiver, and the flag that
    // the hold-off process raises to keep the receiver stalled.
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    logic hold_active  = 1'b0;
    int   cycle_count  = 0;

    pagerank_vertex_apply u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The watchdog ends a run that hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side. A transaction is taken from the values sampled at the edge,
    // before any nonblocking update of this step, and tready for the next
    // cycle is chosen from the current idle rate or forced low by a hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
        end
        if (hold_active) begin
            m_axis_tready <= 1'b0;
        end else if (rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one vertex, with random idle cycles in front of it, and note it in
    // the scoreboard at the edge where the transaction completes. Valid stays
    // high afterwards so that back-to-back vertices need no second assignment
    // in the same step.
    task automatic send_vertex(input logic [31:0] rank_sum, input logic [31:0] prior_score,
                               input logic [30:0] out_degree, input logic last);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, out_degree, prior_score, rank_sum};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_vertex(rank_sum, prior_score, out_degree, last);
    endtask

    // Stop offering, wait for every expected result, then let the pipeline
    // settle so that a register write cannot hit a vertex in flight.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both registers and then one index that decodes to nothing. The
    // write enable is only lowered after the last write.
    task automatic apply_setting(input logic [31:0] base_data, input logic [31:0] damp_data);
        logic [CFG_INDEX_W-1:0] spare;
        spare = $urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO;
        cfg_we    <= 1'b1;
        cfg_index <= REG_BASE_SCORE;
        cfg_wdata <= base_data;
        @(posedge aclk);
        sb.set_reg(REG_BASE_SCORE, base_data);
        cfg_index <= REG_DAMPING_FACTOR;
        cfg_wdata <= damp_data;
        @(posedge aclk);
        sb.set_reg(REG_DAMPING_FACTOR, damp_data);
        cfg_index <= spare;
        cfg_wdata <= $urandom();
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Signed operand mix: corners, small values of either sign, and full range.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1:       return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom_range(2000)) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    // Degrees lean toward zero, one and small values, where the quotient is
    // non-trivial, with the full range and the maximum mixed in.
    function automatic logic [30:0] pick_degree();
        case ($urandom_range(9))
            0:          return '0;
            1:          return 31'd1;
            2:          return 31'h7FFF_FFFF;
            3, 4, 5:    return 31'($urandom_range(64, 1));
            default:    return 31'($urandom());
        endcase
    endfunction

    task automatic random_vertices(input int count);
        for (int i = 0; i < count; i++) begin
            send_vertex(pick_word(), pick_word(), pick_degree(), $urandom_range(7) == 0);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed vertices at the reset register values: zero everything,
        // the rank sum extremes, a negative score that truncates toward zero,
        // and a zero degree that still adds to the error total on a last item.
        send_vertex(32'h0000_0000, 32'h0000_0000, 31'd0, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h0000_0000, 31'd1, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 1'b0);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_vertex(32'd1000, 32'h8000_0000, 31'd3, 1'b1);
        send_vertex(-32'sd1000, 32'd5, 31'd7, 1'b0);
        send_vertex(32'd12345, 32'd0, 31'd0, 1'b1);
        drain();

        // Zero damping makes the score equal the base, which reaches the most
        // negative score: its quotient by one and the wrapped difference
        // against zero both keep 0x80000000.
        apply_setting(32'h8000_0000, 32'h0000_0000);
        send_vertex(32'h1234_5678, 32'h0000_0001, 31'd1, 1'b0);
        send_vertex(32'hDEAD_BEEF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_vertex(32'h0000_0000, 32'h0000_0000, 31'd2, 1'b0);
        send_vertex(32'hFFFF_FFFF, 32'h8000_0000, 31'd0, 1'b1);
        drain();

        // Largest base and damping; the upper half of the damping write has to
        // be ignored, and the product and base addition wrap.
        apply_setting(32'hFFFF_FFFF, 32'hABCD_FFFF);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 31'h4000_0000, 1'b0);
        send_vertex(32'h1234_5678, 32'hFFFF_FFFF, 31'd5, 1'b1);
        drain();

        // Random part. The sender idles 22 percent and the receiver 48 first,
        // then the other way round, then neither idles.
        snd_idle_pct = 22;
        rcv_idle_pct = 48;
        apply_setting(32'h0000_0000, 32'd108);
        random_vertices(PHASE_ITEMS);
        drain();
        apply_setting($urandom(), $urandom());
        random_vertices(PHASE_ITEMS);
        drain();

        snd_idle_pct = 48;
        rcv_idle_pct = 22;
        apply_setting(32'hFFFF_FFFF, 32'h0000_FFFF);
        random_vertices(PHASE_ITEMS);
        drain();
        apply_setting($urandom(), 32'h0000_0000);
        random_vertices(PHASE_ITEMS);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        apply_setting(32'h8000_0000, 32'd1);
        random_vertices(PHASE_ITEMS);
        drain();

        // The receiver stalls for a long stretch while the sender keeps
        // offering vertices, so the output holds a result and the block has
        // to stall its input.
        apply_setting($urandom(), 32'd108);
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active <= 1'b0;
            end
        join_none
        random_vertices(PHASE_ITEMS);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
